// ===== rtl/afab_pkg.sv =====
package afab_pkg;

   // Fixed constants of the feature and AGC arithmetic.
   localparam int NORM_TOP          = 304;
   localparam int NORM_MAX          = 400;
   localparam int VALLEY_PERIOD     = 50;
   localparam int VALLEY_GAP        = 16;
   localparam int MIN_RANGE         = 24;
   localparam int PEAK_DECAY_SHIFT  = 11;
   localparam int VALLEY_FALL_SHIFT = 3;
   localparam int LPF_SHIFT         = 2;
   localparam int FEAT_EMA_SHIFT    = 3;
   localparam int SLOW_AVG_SHIFT    = 9;
   localparam int MAX_LEVEL_SHIFT   = 8;

   // Reset values of the configuration registers.
   localparam logic [3:0]  RST_LEVEL_SHIFT = 4'd3;
   localparam logic [15:0] RST_HOLDOFF     = 16'd200;
   localparam logic [11:0] RST_MIN_BASS    = 12'd8;
   localparam logic [9:0]  RST_PEAK_FLOOR  = 10'd48;

   // Input operation codes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_LEVEL_SHIFT = 2'd0,
      REG_HOLDOFF     = 2'd1,
      REG_MIN_BASS    = 2'd2,
      REG_PEAK_FLOOR  = 2'd3
   } reg_index_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FEAT1,
      ST_FEAT2,
      ST_AGC,
      ST_DIV,
      ST_STORE,
      ST_SLOW,
      ST_BEAT,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       clear;
      logic       feat1;
      logic       feat2;
      logic       agc;
      logic       store;
      logic       slow;
      logic       beat;
      logic       out_load;
      logic [1:0] chan;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

// ===== rtl/afab_div.sv =====
module afab_div #(
   parameter int DW = 24,
   parameter int FW = 15
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [FW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic          done
);
   localparam int CW = $clog2(DW);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [FW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [FW-1:0] dvs_ff, dvs_in;
   logic [FW:0]   shifted;
   logic [FW:0]   diff;
   logic          ge;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = CW'(DW - 1);
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[FW-1:0] : shifted[FW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/afab_ctrl.sv =====
module afab_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output afab_pkg::cmd_type    cmd,
   input  afab_pkg::status_type status
);
   import afab_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] chan_ff, chan_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_CLEAR) ? ST_CLEAR : ST_FEAT1;
            end
         end
         ST_CLEAR: state_in = ST_DONE;
         ST_FEAT1: state_in = ST_FEAT2;
         ST_FEAT2: state_in = ST_AGC;
         ST_AGC:   state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: state_in = (chan_ff == 2'd2) ? ST_SLOW : ST_AGC;
         ST_SLOW:  state_in = ST_BEAT;
         ST_BEAT:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd          = '0;
      cmd.chan     = chan_ff;
      chan_in      = chan_ff;
      req_stall    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            chan_in   = 2'd0;
         end
         ST_CLEAR: cmd.clear = 1'b1;
         ST_FEAT1: cmd.feat1 = 1'b1;
         ST_FEAT2: cmd.feat2 = 1'b1;
         ST_AGC:   cmd.agc   = 1'b1;
         ST_DIV:   cmd       = cmd;
         ST_STORE: begin
            cmd.store = 1'b1;
            chan_in   = chan_ff + 2'd1;
         end
         ST_SLOW:  cmd.slow     = 1'b1;
         ST_BEAT:  cmd.beat     = 1'b1;
         ST_DONE:  cmd.out_load = out_free;
         default:  req_stall    = 1'b1;
      endcase
   end

   // The result word stays until the receiver takes it.
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/afab_dp.sv =====
module afab_dp #(
   parameter int SAMPLE_BITS = 13
) (
   input  logic                   clock,
   input  logic                   reset,
   input  afab_pkg::cmd_type      cmd,
   output afab_pkg::status_type   status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic [31:0]            req_now_ms,
   input  logic [3:0]             cfg_level_shift,
   input  logic [15:0]            cfg_holdoff,
   input  logic [11:0]            cfg_min_bass,
   input  logic [9:0]             cfg_peak_floor,
   output logic [8:0]             rsp_norm_level,
   output logic [8:0]             rsp_norm_bass,
   output logic [8:0]             rsp_norm_treble,
   output logic                   rsp_beat_pulse,
   output logic [31:0]            rsp_beat_total
);
   import afab_pkg::*;

   localparam int W  = SAMPLE_BITS;
   localparam int FW = (W + 2 > 13) ? W + 2 : 13;
   localparam int DW = FW + 9;

   logic signed [W-1:0]  ac_ff;
   logic [31:0]          now_ff;
   logic signed [FW-1:0] level_ff, bf_ff, bass_ff, treble_ff, slow_ff;
   logic signed [FW-1:0] peak_ff [3];
   logic signed [FW-1:0] valley_ff [3];
   logic [5:0]           tick_ff [3];
   logic [8:0]           norm_ff [3];
   logic                 zero_ff;
   logic                 pulse_ff;
   logic [31:0]          last_ff, count_ff;
   logic [8:0]           o_level_ff, o_bass_ff, o_treble_ff;
   logic                 o_pulse_ff;
   logic [31:0]          o_total_ff;

   logic signed [FW-1:0] ac_x, abs_ac, abs_bf, hp, abs_hp, floor_x;
   logic [3:0]           sh;
   logic signed [FW-1:0] level_in, bf_in, bass_in, treble_in, slow_in;
   logic signed [FW-1:0] x, p, v, p_in, v_in, gap_v, rng, num;
   logic [5:0]           t, t_in;
   logic                 zero_in;
   logic [DW-1:0]        dividend;
   logic [FW-1:0]        divisor;
   logic [DW-1:0]        quotient;
   logic [8:0]           norm_sat;
   logic                 beat_fire;
   logic [31:0]          since;
   logic                 div_done;

   assign ac_x    = {{(FW-W){ac_ff[W-1]}}, ac_ff};
   assign floor_x = FW'(cfg_peak_floor);
   assign sh      = (cfg_level_shift > 4'(MAX_LEVEL_SHIFT)) ? 4'(MAX_LEVEL_SHIFT)
                                                            : cfg_level_shift;

   // Level EMA and bass low-pass, first feature cycle.
   always_comb begin
      abs_ac   = ac_x[FW-1] ? -ac_x : ac_x;
      level_in = level_ff + ((abs_ac - level_ff) >>> sh);
      bf_in    = bf_ff + ((ac_x - bf_ff) >>> LPF_SHIFT);
   end

   // Bass and treble EMAs, second feature cycle, and the slow bass average.
   always_comb begin
      abs_bf    = bf_ff[FW-1] ? -bf_ff : bf_ff;
      hp        = ac_x - bf_ff;
      abs_hp    = hp[FW-1] ? -hp : hp;
      bass_in   = bass_ff + ((abs_bf - bass_ff) >>> FEAT_EMA_SHIFT);
      treble_in = treble_ff + ((abs_hp - treble_ff) >>> FEAT_EMA_SHIFT);
      slow_in   = slow_ff + ((bass_ff - slow_ff) >>> SLOW_AVG_SHIFT);
   end

   // AGC update of the selected channel and the divider operands.
   always_comb begin
      unique case (cmd.chan)
         2'd0:    x = level_ff;
         2'd1:    x = bass_ff;
         default: x = treble_ff;
      endcase
      p = peak_ff[cmd.chan];
      v = valley_ff[cmd.chan];
      t = tick_ff[cmd.chan];

      // Peak jumps up at once and decays slowly toward the floor.
      if (x > p) begin
         p_in = x;
      end else if (p > floor_x) begin
         p_in = p - (((p - floor_x) >>> PEAK_DECAY_SHIFT) + FW'(1));
      end else begin
         p_in = p;
      end

      // Valley falls fast and creeps up once per period.
      t_in = t;
      v_in = v;
      if (x < v) begin
         v_in = v + ((x - v) >>> VALLEY_FALL_SHIFT);
         if (v_in[FW-1]) begin
            v_in = '0;
         end
      end else begin
         t_in = t + 6'd1;
         if (t_in >= 6'(VALLEY_PERIOD)) begin
            t_in = '0;
            if (v < x) begin
               v_in = v + FW'(1);
            end
         end
      end
      gap_v = p_in - FW'(VALLEY_GAP);
      if (v_in > gap_v) begin
         v_in = gap_v;
      end

      rng = p_in - v_in;
      if (rng < FW'(MIN_RANGE)) begin
         rng = FW'(MIN_RANGE);
      end
      num      = x - v_in;
      zero_in  = (num <= FW'(0));
      dividend = DW'(unsigned'(num)) * DW'(NORM_TOP);
      divisor  = unsigned'(rng);
   end

   afab_div #(
      .DW (DW),
      .FW (FW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.agc),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.div_done = div_done;
   assign norm_sat = zero_ff ? 9'd0
                   : (quotient > DW'(NORM_MAX)) ? 9'(NORM_MAX) : quotient[8:0];

   // Beat test against the updated slow average.
   always_comb begin
      since     = now_ff - last_ff;
      beat_fire = (bass_ff > slow_ff + (slow_ff >>> 1))
               && (bass_ff > FW'(cfg_min_bass))
               && (since > 32'(cfg_holdoff));
   end

   // Feature, AGC and beat state.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         level_ff  <= '0;
         bf_ff     <= '0;
         bass_ff   <= '0;
         treble_ff <= '0;
         slow_ff   <= '0;
         pulse_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            peak_ff[i]   <= reset ? FW'(RST_PEAK_FLOOR) : floor_x;
            valley_ff[i] <= '0;
            tick_ff[i]   <= '0;
            norm_ff[i]   <= '0;
         end
      end else begin
         if (cmd.feat1) begin
            level_ff <= level_in;
            bf_ff    <= bf_in;
         end
         if (cmd.feat2) begin
            bass_ff   <= bass_in;
            treble_ff <= treble_in;
         end
         if (cmd.agc) begin
            peak_ff[cmd.chan]   <= p_in;
            valley_ff[cmd.chan] <= v_in;
            tick_ff[cmd.chan]   <= t_in;
         end
         if (cmd.store) begin
            norm_ff[cmd.chan] <= norm_sat;
         end
         if (cmd.slow) begin
            slow_ff <= slow_in;
         end
         if (cmd.beat) begin
            pulse_ff <= beat_fire;
         end
      end
   end

   // Beat count and time survive a clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.beat && beat_fire) begin
         last_ff  <= now_ff;
         count_ff <= count_ff + 32'd1;
      end
   end

   // Input word capture, zero flag and result word.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ac_ff  <= req_sample;
         now_ff <= req_now_ms;
      end
      if (cmd.agc) begin
         zero_ff <= zero_in;
      end
      if (cmd.out_load) begin
         o_level_ff  <= norm_ff[0];
         o_bass_ff   <= norm_ff[1];
         o_treble_ff <= norm_ff[2];
         o_pulse_ff  <= pulse_ff;
         o_total_ff  <= count_ff;
      end
   end

   assign rsp_norm_level  = o_level_ff;
   assign rsp_norm_bass   = o_bass_ff;
   assign rsp_norm_treble = o_treble_ff;
   assign rsp_beat_pulse  = o_pulse_ff;
   assign rsp_beat_total  = o_total_ff;

endmodule

// ===== rtl/audio_feature_agc_beat.sv =====
// Audio feature extractor with three AGC-normalized outputs (level, bass,
// treble on 0..400) and a bass beat detector with holdoff and a running
// beat count. Each input word gives exactly one result word. A clear word
// (op = 1) resets filters and AGCs and keeps the beat count. A sample word
// passes its three AGC channels in turn through the single bit-serial
// divider that they share; the divider's dividend is DW = FW+9 bits wide,
// where FW = max(SAMPLE_BITS+2, 13). A finished result waits in an output
// register, and the next word is accepted as soon as the controller is
// idle again.
module audio_feature_agc_beat #(
   parameter int SAMPLE_BITS = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic [31:0]                   req_now_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [8:0]                    rsp_norm_level,
   output logic [8:0]                    rsp_norm_bass,
   output logic [8:0]                    rsp_norm_treble,
   output logic                          rsp_beat_pulse,
   output logic [31:0]                   rsp_beat_total,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import afab_pkg::*;

   logic [3:0]    level_shift_ff;
   logic [15:0]   holdoff_ff;
   logic [11:0]   min_bass_ff;
   logic [9:0]    peak_floor_ff;
   logic          wr_en;
   reg_index_type reg_idx;
   cmd_type       cmd;
   status_type    status;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_index_type'(paddr[3:2]);

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_shift_ff <= RST_LEVEL_SHIFT;
         holdoff_ff     <= RST_HOLDOFF;
         min_bass_ff    <= RST_MIN_BASS;
         peak_floor_ff  <= RST_PEAK_FLOOR;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_LEVEL_SHIFT: level_shift_ff <= pwdata[3:0];
            REG_HOLDOFF:     holdoff_ff     <= pwdata[15:0];
            REG_MIN_BASS:    min_bass_ff    <= pwdata[11:0];
            REG_PEAK_FLOOR:  peak_floor_ff  <= pwdata[9:0];
            default:         level_shift_ff <= level_shift_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (reg_idx)
         REG_LEVEL_SHIFT: prdata = 32'(level_shift_ff);
         REG_HOLDOFF:     prdata = 32'(holdoff_ff);
         REG_MIN_BASS:    prdata = 32'(min_bass_ff);
         REG_PEAK_FLOOR:  prdata = 32'(peak_floor_ff);
         default:         prdata = '0;
      endcase
   end

   afab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   afab_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .req_now_ms      (req_now_ms),
      .cfg_level_shift (level_shift_ff),
      .cfg_holdoff     (holdoff_ff),
      .cfg_min_bass    (min_bass_ff),
      .cfg_peak_floor  (peak_floor_ff),
      .rsp_norm_level  (rsp_norm_level),
      .rsp_norm_bass   (rsp_norm_bass),
      .rsp_norm_treble (rsp_norm_treble),
      .rsp_beat_pulse  (rsp_beat_pulse),
      .rsp_beat_total  (rsp_beat_total)
   );

   // An accepted word keeps the input side busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a word was in progress");

   // Normalized outputs never leave their range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_norm_level <= 9'd400) && (rsp_norm_bass <= 9'd400)
                    && (rsp_norm_treble <= 9'd400))
      else $error("normalized output above full scale");

   // A beat is only reported together with a changed beat count.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_beat_total == $past(rsp_beat_total) + 32'(rsp_beat_pulse)
                       || !$past(rsp_valid))
      else $error("beat count out of step with beat pulse");

endmodule

// ===== bench/tb_audio_feature_agc_beat.sv =====
`timescale 1ns / 100ps

module tb_audio_feature_agc_beat;
   import afab_pkg::*;

   localparam int SB = 13;
   localparam int NUM_RANDOM = 1700;
   localparam int STALL_LIMIT = 20000;
   localparam int N_DIRECTED = 20;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_op = OP_SAMPLE;
   logic signed [SB-1:0] req_sample = '0;
   logic [31:0]   req_now_ms = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [8:0]    rsp_norm_level;
   logic [8:0]    rsp_norm_bass;
   logic [8:0]    rsp_norm_treble;
   logic          rsp_beat_pulse;
   logic [31:0]   rsp_beat_total;
   logic          psel = 1'b0;
   logic          penable = 1'b0;
   logic          pwrite = 1'b0;
   logic [3:0]    paddr = '0;
   logic [31:0]   pwdata = '0;
   logic [31:0]   prdata;
   logic          pready;

   audio_feature_agc_beat #(.SAMPLE_BITS(SB)) dut (.*);

   always #5 clock = ~clock;

   // One result word of the block.
   typedef struct packed {
      logic [8:0]  level;
      logic [8:0]  bass;
      logic [8:0]  treble;
      logic        pulse;
      logic [31:0] total;
   } feature_word_type;

   // One directed stimulus row; has_fixed marks a typed-in expectation.
   typedef struct packed {
      logic             op;
      logic [SB-1:0]    sample;
      logic [31:0]      now;
      logic             has_fixed;
      feature_word_type fixed;
   } stim_row_type;

   // Shadow configuration and feature state.
   logic [3:0]  cfg_shift;
   logic [15:0] cfg_holdoff;
   logic [11:0] cfg_min_bass;
   logic [9:0]  cfg_floor;
   int          lpf_state, lvl_ema, bass_ema, treb_ema, bass_slow;
   int          peak [3];
   int          valley [3];
   int          valley_tick [3];
   logic [31:0] last_beat_ms, beat_count;

   feature_word_type pending_words [$];
   int               error_count = 0;
   int               words_checked = 0;
   int               beats_seen = 0;
   int               idle_cycles = 0;
   bit               quiet_sides = 1'b0;

   // Floor shift that also works on negative values.
   function automatic int shr_floor(int v, int s);
      return v >>> s;
   endfunction

   function automatic int mag(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void clear_features();
      lpf_state = 0; lvl_ema = 0; bass_ema = 0; treb_ema = 0; bass_slow = 0;
      for (int i = 0; i < 3; i++) begin
         peak[i] = int'(cfg_floor);
         valley[i] = 0;
         valley_tick[i] = 0;
      end
   endfunction

   // Peak/valley tracker of one channel, returning the 0..400 level.
   function automatic logic [8:0] agc_normalize(int ch, int x);
      int flr, span, n;
      flr = int'(cfg_floor);
      if (x > peak[ch]) begin
         peak[ch] = x;
      end else if (peak[ch] > flr) begin
         peak[ch] -= shr_floor(peak[ch] - flr, PEAK_DECAY_SHIFT) + 1;
      end
      if (x < valley[ch]) begin
         valley[ch] += shr_floor(x - valley[ch], VALLEY_FALL_SHIFT);
         if (valley[ch] < 0) valley[ch] = 0;
      end else begin
         valley_tick[ch]++;
         if (valley_tick[ch] >= VALLEY_PERIOD) begin
            valley_tick[ch] = 0;
            if (valley[ch] < x) valley[ch]++;
         end
      end
      if (valley[ch] > peak[ch] - VALLEY_GAP) valley[ch] = peak[ch] - VALLEY_GAP;
      span = peak[ch] - valley[ch];
      if (span < MIN_RANGE) span = MIN_RANGE;
      n = x - valley[ch];
      if (n <= 0) return '0;
      n = (n * NORM_TOP) / span;
      if (n > NORM_MAX) n = NORM_MAX;
      return n[8:0];
   endfunction

   // Computes the result word of one input word and advances the state.
   function automatic feature_word_type predict_features(logic op, logic [SB-1:0] raw,
                                                         logic [31:0] now);
      feature_word_type w;
      int ac, sh;
      w = '0;
      if (op == OP_CLEAR) begin
         clear_features();
         w.total = beat_count;
         return w;
      end
      ac = int'($signed(raw));
      sh = (cfg_shift > MAX_LEVEL_SHIFT) ? MAX_LEVEL_SHIFT : int'(cfg_shift);
      lvl_ema += shr_floor(mag(ac) - lvl_ema, sh);
      lpf_state += shr_floor(ac - lpf_state, LPF_SHIFT);
      bass_ema += shr_floor(mag(lpf_state) - bass_ema, FEAT_EMA_SHIFT);
      treb_ema += shr_floor(mag(ac - lpf_state) - treb_ema, FEAT_EMA_SHIFT);
      w.level = agc_normalize(0, lvl_ema);
      w.bass = agc_normalize(1, bass_ema);
      w.treble = agc_normalize(2, treb_ema);
      bass_slow += shr_floor(bass_ema - bass_slow, SLOW_AVG_SHIFT);
      if (bass_ema > bass_slow + shr_floor(bass_slow, 1) &&
          bass_ema > int'(cfg_min_bass) &&
          (now - last_beat_ms) > {16'd0, cfg_holdoff}) begin
         last_beat_ms = now;
         beat_count++;
         w.pulse = 1'b1;
      end
      w.total = beat_count;
      return w;
   endfunction

   // Register write over the configuration port, shadowed in the predictor.
   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_LEVEL_SHIFT: cfg_shift = value[3:0];
         REG_HOLDOFF:     cfg_holdoff = value[15:0];
         REG_MIN_BASS:    cfg_min_bass = value[11:0];
         REG_PEAK_FLOOR:  cfg_floor = value[9:0];
      endcase
   endtask

   // Sends one word and queues its prediction once it is accepted. Valid
   // stays high after the accepting edge so that words can follow at once;
   // it drops on an idle cycle or when the sender stops.
   task automatic send_word(logic op, logic [SB-1:0] raw, logic [31:0] now,
                            bit has_fixed, feature_word_type fixed);
      feature_word_type w;
      while (!quiet_sides && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_op <= op; req_sample <= raw; req_now_ms <= now;
      do @(posedge clock); while (req_stall);
      w = predict_features(op, raw, now);
      if (has_fixed && w != fixed) begin
         error_count++;
         if (error_count <= 10)
            $display("directed row mismatch: typed %h predicted %h", fixed, w);
      end
      pending_words.push_back(w);
   endtask

   // Stops sending and waits until every expected word has come back.
   task automatic wait_all_words();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic drain_block();
      wait_all_words();
      repeat (100) @(posedge clock);
   endtask

   // Result side: random stall and field-by-field comparison.
   always @(posedge clock) begin
      feature_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("unexpected result word");
            end else begin
               want = pending_words.pop_front();
               words_checked++;
               if (rsp_beat_pulse) beats_seen++;
               if (rsp_norm_level !== want.level || rsp_norm_bass !== want.bass ||
                   rsp_norm_treble !== want.treble ||
                   rsp_beat_pulse !== want.pulse || rsp_beat_total !== want.total) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"word %0d: exp lvl %0d bass %0d treb %0d beat %0d ",
                               "total %0d, got %0d %0d %0d %0d %0d"},
                              words_checked, want.level, want.bass, want.treble,
                              want.pulse, want.total, rsp_norm_level, rsp_norm_bass,
                              rsp_norm_treble, rsp_beat_pulse, rsp_beat_total);
               end
            end
         end
         rsp_stall <= quiet_sides ? 1'b0 : ($urandom_range(99) < 24);
      end
   end

   // Watchdog on cycles without any handshake on either side or the register port.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Beat-like tone burst: loud low-frequency swing after quiet.
   function automatic logic [SB-1:0] burst_sample(int k, int amp);
      return ((k / 4) % 2) ? SB'(amp) : SB'(-amp);
   endfunction

   initial begin
      stim_row_type     rows [N_DIRECTED];
      feature_word_type zero_word;
      logic [31:0]      clock_ms;
      int               amp;
      zero_word = '0;
      // Directed rows: the first two have fixed results, the rest use the predictor.
      rows[0]  = '{OP_CLEAR,  SB'(0),     32'd0,          1'b1, zero_word};
      rows[1]  = '{OP_SAMPLE, SB'(0),     32'd1,          1'b1, zero_word};
      rows[2]  = '{OP_SAMPLE, SB'(4095),  32'd2,          1'b0, zero_word};
      rows[3]  = '{OP_SAMPLE, SB'(-4096), 32'd3,          1'b0, zero_word};
      rows[4]  = '{OP_SAMPLE, SB'(4095),  32'd300,        1'b0, zero_word};
      rows[5]  = '{OP_SAMPLE, SB'(4095),  32'd600,        1'b0, zero_word};
      rows[6]  = '{OP_SAMPLE, SB'(-4096), 32'd900,        1'b0, zero_word};
      rows[7]  = '{OP_SAMPLE, SB'(-1),    32'hFFFF_FFFF,  1'b0, zero_word};
      rows[8]  = '{OP_SAMPLE, SB'(1),     32'h0000_0010,  1'b0, zero_word};
      rows[9]  = '{OP_CLEAR,  SB'(4095),  32'hFFFF_FFFF,  1'b0, zero_word};
      for (int i = 10; i < N_DIRECTED; i++)
         rows[i] = '{OP_SAMPLE, ((i % 2) ? SB'(3000) : SB'(-3000)),
                     32'(1000 * i), 1'b0, zero_word};

      cfg_shift = RST_LEVEL_SHIFT; cfg_holdoff = RST_HOLDOFF;
      cfg_min_bass = RST_MIN_BASS; cfg_floor = RST_PEAK_FLOOR;
      clear_features();
      last_beat_ms = '0; beat_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_word(rows[i].op, rows[i].sample, rows[i].now, rows[i].has_fixed,
                   rows[i].fixed);
      drain_block();

      // Extremes of the registers, including the shift above its saturation
      // and a floor below the valley gap.
      write_reg(REG_LEVEL_SHIFT, 32'd15);
      write_reg(REG_HOLDOFF, 32'd0);
      write_reg(REG_MIN_BASS, 32'd0);
      write_reg(REG_PEAK_FLOOR, 32'd0);
      for (int k = 0; k < 40; k++)
         send_word(OP_SAMPLE, SB'($urandom), $urandom, 1'b0, zero_word);
      drain_block();

      // Random phases: mostly bursts between quiet stretches, some noise,
      // an occasional clear, with settings changed between phases.
      clock_ms = 32'hFFFF_F000;
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_LEVEL_SHIFT, (ph == 1) ? 32'd0 : (ph == 2) ? 32'd8 : $urandom_range(15));
         write_reg(REG_HOLDOFF, (ph == 3) ? 32'd65535 : $urandom_range(300));
         write_reg(REG_MIN_BASS, (ph == 4) ? 32'd4095 : $urandom_range(40));
         write_reg(REG_PEAK_FLOOR, (ph == 5) ? 32'd1023 : (ph == 6) ? 32'd16 :
                                   $urandom_range(1023));
         quiet_sides = (ph == 2);
         for (int k = 0; k < NUM_RANDOM / 8; k++) begin
            clock_ms += $urandom_range(3);
            amp = ((k % 60) < 12) ? $urandom_range(4095) : $urandom_range(40);
            if ($urandom_range(99) < 2)
               send_word(OP_CLEAR, SB'($urandom), $urandom, 1'b0, zero_word);
            else if ($urandom_range(99) < 15)
               send_word(OP_SAMPLE, SB'($urandom), clock_ms, 1'b0, zero_word);
            else
               send_word(OP_SAMPLE, burst_sample(k + $urandom_range(1), amp), clock_ms,
                         1'b0, zero_word);
            if (k == 100 && ph == 0) begin
               // Sender holds off until the block has delivered everything.
               wait_all_words();
            end
         end
         drain_block();
      end
      quiet_sides = 1'b0;

      $display("Checked %0d result words, %0d with a beat, over ten register settings.",
               words_checked, beats_seen);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/afab_pkg.sv
rtl/afab_div.sv
rtl/afab_ctrl.sv
rtl/afab_dp.sv
rtl/audio_feature_agc_beat.sv
bench/tb_audio_feature_agc_beat.sv
